// File: hdl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/i2cee_pkg.sv
// package with types and constants of the i2c eeprom master
`default_nettype none

package i2cee_pkg;

  localparam int BUFFER_BYTES_DEF = 16;

  // buffer address bus covers the largest legal buffer
  localparam int PBUF_AW = 8;

  localparam logic [6:0] DEV_ADDR_RST = 7'd80;
  localparam logic       RW_READ      = 1'b1;
  localparam logic       RW_WRITE     = 1'b0;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] word_address;
    logic [7:0] data_byte;
    logic [7:0] byte_count;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       read_valid;
    logic [7:0] read_data;
    logic       read_last;
    logic       done_res;
    logic       all_acked;
    logic       rejected;
  } out_t;

  // page buffer access from the sequencer
  typedef struct packed {
    logic               we;
    logic [PBUF_AW-1:0] waddr;
    logic [7:0]         wdata;
    logic               rd_ok;
    logic [PBUF_AW-1:0] raddr;
  } pbuf_req_t;

endpackage

`default_nettype wire

// File: hdl/i2cee_pbuf.sv
// page buffer memory with one write port and a registered read port
`default_nettype none

module i2cee_pbuf
  import i2cee_pkg::*;
#(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  wire logic      clk,
  input  wire pbuf_req_t req,
  output logic [7:0]     rd_data
);

  localparam int IW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;

  logic [7:0] mem [BUFFER_BYTES];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[IW-1:0]] <= req.wdata;
    end
  end

  // out-of-range reads give zero
  always_ff @(posedge clk) begin
    if (req.rd_ok) begin
      rd_data_r <= mem[req.raddr[IW-1:0]];
    end else begin
      rd_data_r <= 8'd0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: hdl/i2cee_ctrl.sv
// bus sequencer: start, address, data, read and stop phases
`default_nettype none

module i2cee_ctrl
  import i2cee_pkg::*;
#(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       adv,
  input  wire in_t        in_data,
  input  wire logic [6:0] dev_addr,
  input  wire logic [7:0] rd_data,
  output pbuf_req_t       pbuf_req,
  output out_t            res
);

  `include "assert_macros.svh"

  localparam int CW = $clog2(BUFFER_BYTES + 1);
  localparam logic [CW-1:0] BB_C  = CW'(BUFFER_BYTES);
  localparam logic [CW:0]   BB_C1 = (CW+1)'(BUFFER_BYTES);

  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_START1 = 4'd1;
  localparam logic [3:0] PH_DEVW   = 4'd2;
  localparam logic [3:0] PH_WORD   = 4'd3;
  localparam logic [3:0] PH_START2 = 4'd4;
  localparam logic [3:0] PH_DEVR   = 4'd5;
  localparam logic [3:0] PH_DATA   = 4'd6;
  localparam logic [3:0] PH_RX     = 4'd7;
  localparam logic [3:0] PH_STOP   = 4'd8;

  logic [3:0]    phase_r, phase_nxt;
  logic [1:0]    step_r, step_nxt;
  logic [3:0]    bit_r, bit_nxt;
  logic [7:0]    shift_r, shift_nxt;
  logic [7:0]    addr_r, addr_nxt;
  logic [7:0]    left_r, left_nxt;
  logic [CW-1:0] widx_r, widx_nxt;
  logic [CW-1:0] lcnt_r, lcnt_nxt;
  logic          ack_r, ack_nxt;
  logic          rjob_r, rjob_nxt;
  logic          scl_r, scl_nxt;
  logic          sda_r, sda_nxt;

  logic [7:0] dev_w;
  logic [CW:0] pf_addr;
  logic [8:0]  bc_ext;
  logic [8:0]  lc_ext;
  logic        done;

  assign dev_w  = {dev_addr, RW_WRITE};
  assign bc_ext = 9'(in_data.byte_count);
  assign lc_ext = 9'(lcnt_r);

  // prefetch the byte the next data phase will need
  always_comb begin
    if (phase_r == PH_DATA) begin
      pf_addr = (CW+1)'(widx_r) + (CW+1)'(1);
    end else begin
      pf_addr = (CW+1)'(widx_r);
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    step_nxt  = step_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    addr_nxt  = addr_r;
    left_nxt  = left_r;
    widx_nxt  = widx_r;
    lcnt_nxt  = lcnt_r;
    ack_nxt   = ack_r;
    rjob_nxt  = rjob_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    done      = 1'b0;
    res       = '0;

    pbuf_req.we    = 1'b0;
    pbuf_req.waddr = PBUF_AW'(lcnt_r);
    pbuf_req.wdata = in_data.data_byte;
    pbuf_req.rd_ok = (pf_addr < BB_C1);
    pbuf_req.raddr = PBUF_AW'(pf_addr);

    if (phase_r == PH_IDLE) begin
      case (in_data.operation)
        OP_LOAD: begin
          if (lcnt_r < BB_C) begin
            pbuf_req.we = adv;
            lcnt_nxt    = lcnt_r + CW'(1);
          end else begin
            res.rejected = 1'b1;
          end
        end
        OP_WRITE: begin
          left_nxt  = (bc_ext > lc_ext) ? 8'(lc_ext) : in_data.byte_count;
          widx_nxt  = '0;
          lcnt_nxt  = '0;
          rjob_nxt  = 1'b0;
          addr_nxt  = in_data.word_address;
          ack_nxt   = 1'b1;
          phase_nxt = PH_START1;
          shift_nxt = 8'd0;
          bit_nxt   = 4'd0;
          step_nxt  = 2'd0;
        end
        OP_READ: begin
          if (in_data.byte_count == 8'd0) begin
            res.rejected = 1'b1;
          end else begin
            rjob_nxt  = 1'b1;
            left_nxt  = in_data.byte_count;
            addr_nxt  = in_data.word_address;
            ack_nxt   = 1'b1;
            phase_nxt = PH_START1;
            shift_nxt = 8'd0;
            bit_nxt   = 4'd0;
            step_nxt  = 2'd0;
          end
        end
        default: ;
      endcase
    end else begin
      res.rejected = (in_data.operation != OP_TICK);
      case (phase_r)
        PH_START1, PH_START2: begin
          if (step_r == 2'd0) begin
            scl_nxt = 1'b0; sda_nxt = 1'b1; step_nxt = 2'd1;
          end else if (step_r == 2'd1) begin
            scl_nxt = 1'b1; sda_nxt = 1'b1; step_nxt = 2'd2;
          end else begin
            scl_nxt  = 1'b1;
            sda_nxt  = 1'b0;
            bit_nxt  = 4'd0;
            step_nxt = 2'd0;
            if (phase_r == PH_START1) begin
              phase_nxt = PH_DEVW;
              shift_nxt = dev_w;
            end else begin
              phase_nxt = PH_DEVR;
              shift_nxt = {dev_addr, RW_READ};
            end
          end
        end
        PH_STOP: begin
          if (step_r == 2'd0) begin
            scl_nxt = 1'b0; sda_nxt = 1'b0; step_nxt = 2'd1;
          end else if (step_r == 2'd1) begin
            scl_nxt = 1'b1; sda_nxt = 1'b0; step_nxt = 2'd2;
          end else begin
            scl_nxt   = 1'b1;
            sda_nxt   = 1'b1;
            shift_nxt = 8'd0;
            bit_nxt   = 4'd0;
            step_nxt  = 2'd0;
            if (rjob_r) begin
              addr_nxt = addr_r + 8'd1;
              if (left_r != 8'd0) begin
                left_nxt = left_r - 8'd1;
              end
            end
            if (rjob_r && left_nxt != 8'd0) begin
              phase_nxt = PH_START1;
            end else begin
              phase_nxt     = PH_IDLE;
              done          = 1'b1;
              res.all_acked = ack_r;
            end
          end
        end
        PH_RX: begin
          scl_nxt = (step_r != 2'd0);
          sda_nxt = 1'b1;
          if (step_r == 2'd0) begin
            step_nxt = 2'd1;
          end else begin
            step_nxt = 2'd0;
            if (bit_r < 4'd8) begin
              shift_nxt = {shift_r[6:0], in_data.sda_in};
              bit_nxt   = bit_r + 4'd1;
              if (bit_r == 4'd7) begin
                res.read_valid = 1'b1;
                res.read_data  = shift_nxt;
                res.read_last  = (left_r == 8'd1);
              end
            end else begin
              phase_nxt = PH_STOP;
              shift_nxt = 8'd0;
              bit_nxt   = 4'd0;
            end
          end
        end
        default: begin
          // transmit phases: device address, word address, data
          if (step_r == 2'd0) begin
            scl_nxt  = 1'b0;
            sda_nxt  = (bit_r < 4'd8) ? shift_r[7] : 1'b1;
            step_nxt = 2'd1;
          end else begin
            scl_nxt  = 1'b1;
            step_nxt = 2'd0;
            if (bit_r < 4'd8) begin
              shift_nxt = {shift_r[6:0], 1'b0};
              bit_nxt   = bit_r + 4'd1;
            end else begin
              sda_nxt = 1'b1;
              if (in_data.sda_in) begin
                ack_nxt = 1'b0;
              end
              bit_nxt = 4'd0;
              case (phase_r)
                PH_DEVW: begin
                  phase_nxt = PH_WORD;
                  shift_nxt = addr_r;
                end
                PH_WORD: begin
                  if (rjob_r) begin
                    phase_nxt = PH_START2;
                    shift_nxt = 8'd0;
                  end else if (left_r != 8'd0) begin
                    phase_nxt = PH_DATA;
                    shift_nxt = rd_data;
                  end else begin
                    phase_nxt = PH_STOP;
                    shift_nxt = 8'd0;
                  end
                end
                PH_DEVR: begin
                  phase_nxt = PH_RX;
                  shift_nxt = 8'd0;
                end
                default: begin
                  widx_nxt = widx_r + CW'(1);
                  if (left_r != 8'd0) begin
                    left_nxt = left_r - 8'd1;
                  end
                  if (left_nxt != 8'd0) begin
                    phase_nxt = PH_DATA;
                    shift_nxt = rd_data;
                  end else begin
                    phase_nxt = PH_STOP;
                    shift_nxt = 8'd0;
                  end
                end
              endcase
            end
          end
        end
      endcase
    end

    res.scl_out  = scl_nxt;
    res.sda_out  = sda_nxt;
    res.busy_res = (phase_nxt != PH_IDLE) || done;
    res.done_res = done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      step_r  <= 2'd0;
      bit_r   <= 4'd0;
      shift_r <= 8'd0;
      addr_r  <= 8'd0;
      left_r  <= 8'd0;
      widx_r  <= '0;
      lcnt_r  <= '0;
      ack_r   <= 1'b1;
      rjob_r  <= 1'b0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
    end else if (adv) begin
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      addr_r  <= addr_nxt;
      left_r  <= left_nxt;
      widx_r  <= widx_nxt;
      lcnt_r  <= lcnt_nxt;
      ack_r   <= ack_nxt;
      rjob_r  <= rjob_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
    end
  end

  `ASSERT_SAME(a_load_only_idle, pbuf_req.we, phase_r == PH_IDLE && !rjob_r || phase_r == PH_IDLE, "buffer written outside idle")
  `ASSERT_SAME(a_fill_bound, 1'b1, lcnt_r <= BB_C, "page buffer fill count overran")
  `ASSERT_SAME(a_rx_byte, res.read_valid, phase_r == PH_RX && rjob_r, "read byte outside receive phase")
  `ASSERT_NEXT(a_done_idle, adv && done, phase_r == PH_IDLE, "done without return to idle")

endmodule

`default_nettype wire

// File: hdl/i2cee_top_unused_guard.sv
// result register stage between the sequencer and the output channel
`default_nettype none

module i2cee_oreg
  import i2cee_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic load,
  input  wire out_t res,
  input  wire logic out_stall,
  output logic      out_valid,
  output out_t      out_data
);

  `include "assert_macros.svh"

  logic valid_r, valid_nxt;
  out_t data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

  `ASSERT_NEXT(a_load_shows, load, valid_r && data_r == $past(res), "loaded word not presented")
  `ASSERT_SAME(a_no_overwrite, load && valid_r, !out_stall, "waiting word overwritten")
  `ASSERT_NEXT(a_done_flags, load && res.done_res, data_r.busy_res, "done word without busy")

endmodule

`default_nettype wire

// File: hdl/i2c_eeprom_master_core.sv
// top level of the i2c serial eeprom master
// Each accepted input word is one half-bit bus tick: it carries the sampled
// SDA level and optionally a command (load a page buffer byte, start a write,
// start a read), and it yields exactly one result word with the SCL/SDA
// levels to drive, busy, a received byte with its last mark, done and the
// all-acknowledged flag. The block takes one word per clock and presents its
// result word on the output register in the cycle after the input word is taken.
// The input stalls only while that register holds a word that the sink
// refuses, so with a free sink words flow back to back. The page buffer memory
// has a registered read port, whose delay is hidden because the sequencer keeps
// the next data byte prefetched from the buffer well before the ack slot that
// needs it. No clearing pass after reset. A write job clamps its
// count to the bytes loaded since the last write; a read job of n bytes runs
// n random reads at rising addresses. Commands given while busy, loads into a
// full buffer and reads of zero bytes come back with the rejected flag set.
// The device address register may be written only while the block is idle.
`default_nettype none

module i2c_eeprom_master_core
  import i2cee_pkg::*;
#(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input words: one bus tick each
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_t        in_data,
  // result words
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_t            out_data,
  // device address register
  input  wire logic       cfg_we,
  input  wire logic [6:0] cfg_wdata
);

  logic [6:0] dev_addr_r;
  logic       adv;
  out_t       res;
  pbuf_req_t  pbuf_req;
  logic [7:0] pbuf_rd;

  // stall only while the result register holds a word the sink refuses
  assign in_stall = out_valid && out_stall;
  assign adv      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= DEV_ADDR_RST;
    end else if (cfg_we) begin
      dev_addr_r <= cfg_wdata;
    end
  end

  // bus phase sequencer
  i2cee_ctrl #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_data  (in_data),
    .dev_addr (dev_addr_r),
    .rd_data  (pbuf_rd),
    .pbuf_req (pbuf_req),
    .res      (res)
  );

  // page buffer
  i2cee_pbuf #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_pbuf (
    .clk     (clk),
    .req     (pbuf_req),
    .rd_data (pbuf_rd)
  );

  // result register
  i2cee_oreg u_oreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
